@@ rtl/hrlp_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP request length parser package
// Shared widths, byte codes, region codes and result types of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrlp_pkg;

   // Width of the internal length value and body counter.
   localparam int LENGTH_WIDTH = 24;
   // Width of the length and count fields on the result channel.
   localparam int OUT_WIDTH = 24;
   localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = {LENGTH_WIDTH{1'b1}};

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [3:0] KEY_LEN = 4'd14;

   typedef enum logic [2:0] {
      REGION_LINE  = 3'd0,
      REGION_KEY   = 3'd1,
      REGION_VALUE = 3'd2,
      REGION_BODY  = 3'd3,
      REGION_DONE  = 3'd4
   } region_type;

   typedef enum logic [1:0] {
      PHASE_BLANK  = 2'd0,
      PHASE_DIGITS = 2'd1,
      PHASE_STOP   = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type               phase;
      logic [LENGTH_WIDTH-1:0] accum;
      logic                    sign;
   } value_state_type;

   typedef struct packed {
      region_type           region;
      logic                 header_end;
      logic [OUT_WIDTH-1:0] content_length;
      logic                 length_negative;
      logic [OUT_WIDTH-1:0] body_count;
      logic                 request_done;
   } result_type;

   // Lower-case header key that arms the length parse.
   function automatic logic [7:0] key_char(input logic [3:0] pos);
      logic [7:0] c;
      unique case (pos)
         4'd0:    c = 8'h63; // c
         4'd1:    c = 8'h6F; // o
         4'd2:    c = 8'h6E; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6E; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2D; // -
         4'd8:    c = 8'h6C; // l
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6E; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Low OUT_WIDTH bits of a length value, zero extended when it is narrower.
   function automatic logic [OUT_WIDTH-1:0] to_out(input logic [LENGTH_WIDTH-1:0] x);
      logic [LENGTH_WIDTH+OUT_WIDTH-1:0] t;
      t = {{OUT_WIDTH{1'b0}}, x};
      return t[OUT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/hrlp_value_unit.sv @@
// ----------------------------------------------------------------------------
// HTTP request length parser value step
// One byte of the atoi style value parse: blanks, sign, saturating digits.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlp_value_unit
   import hrlp_pkg::*;
(
   input  wire logic [7:0]      data_byte,
   input  wire value_state_type cur,
   output value_state_type      nxt
);

   logic                    is_blank;
   logic                    is_digit;
   logic [3:0]              digit_raw;
   logic [LENGTH_WIDTH+3:0] acc_wide;
   logic [LENGTH_WIDTH+3:0] prod;

   assign is_blank = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB) ||
                     (data_byte == CHAR_VT) || (data_byte == CHAR_FF);
   assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   // The ASCII digits sit at 0x30 to 0x39, so the low nibble is the digit value.
   assign digit_raw = data_byte[3:0];
   assign acc_wide  = {4'b0000, cur.accum};
   // Times ten as two shifts, plus the digit.
   assign prod = (acc_wide << 3) + (acc_wide << 1) +
                 {{(LENGTH_WIDTH){1'b0}}, digit_raw};

   always_comb begin
      nxt = cur;
      if (cur.phase != PHASE_STOP) begin
         if (is_digit) begin
            nxt.accum = (prod[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'b0000) ?
                        LENGTH_MAX : prod[LENGTH_WIDTH-1:0];
            nxt.phase = PHASE_DIGITS;
         end else if (cur.phase == PHASE_BLANK && is_blank) begin
            nxt = cur;
         end else if (cur.phase == PHASE_BLANK &&
                      (data_byte == CHAR_PLUS || data_byte == CHAR_MINUS)) begin
            nxt.sign  = (data_byte == CHAR_MINUS);
            nxt.phase = PHASE_DIGITS;
         end else begin
            nxt.phase = PHASE_STOP;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/hrlp_parser.sv @@
// ----------------------------------------------------------------------------
// HTTP request length parser state
// Region tracking, key match, length commit and body count for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlp_parser
   import hrlp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_fire,
   input  wire logic [7:0] data_byte,
   input  wire logic       new_request,
   output result_type      result
);

   region_type              region_ff, region_in;
   logic [3:0]              match_pos_ff, match_pos_in;
   logic                    mismatch_ff, mismatch_in;
   logic                    armed_ff, armed_in;
   value_state_type         value_ff, value_in;
   logic [LENGTH_WIDTH-1:0] length_ff, length_in;
   logic                    negative_ff, negative_in;
   logic [LENGTH_WIDTH-1:0] count_ff, count_in;

   // State as seen by this byte, after an optional new request restart.
   region_type              cur_region;
   logic [3:0]              cur_pos;
   logic                    cur_mismatch;
   logic                    cur_armed;
   value_state_type         cur_value;
   logic [LENGTH_WIDTH-1:0] cur_length;
   logic                    cur_negative;
   logic [LENGTH_WIDTH-1:0] cur_count;

   value_state_type         value_step;
   logic [7:0]              lower_byte;
   logic [LENGTH_WIDTH-1:0] count_inc;
   region_type              out_region;
   logic                    hdr_end;
   logic                    done;

   always_comb begin
      if (new_request) begin
         cur_region   = REGION_LINE;
         cur_pos      = 4'd0;
         cur_mismatch = 1'b0;
         cur_armed    = 1'b0;
         cur_value    = '{phase: PHASE_BLANK, accum: '0, sign: 1'b0};
         cur_length   = '0;
         cur_negative = 1'b0;
         cur_count    = '0;
      end else begin
         cur_region   = region_ff;
         cur_pos      = match_pos_ff;
         cur_mismatch = mismatch_ff;
         cur_armed    = armed_ff;
         cur_value    = value_ff;
         cur_length   = length_ff;
         cur_negative = negative_ff;
         cur_count    = count_ff;
      end
   end

   hrlp_value_unit u_value (
      .data_byte (data_byte),
      .cur       (cur_value),
      .nxt       (value_step)
   );

   assign lower_byte = (data_byte >= 8'h41 && data_byte <= 8'h5A) ?
                       (data_byte + 8'h20) : data_byte;
   assign count_inc  = (cur_count < LENGTH_MAX) ?
                       (cur_count + {{(LENGTH_WIDTH-1){1'b0}}, 1'b1}) : cur_count;

   always_comb begin
      region_in    = cur_region;
      match_pos_in = cur_pos;
      mismatch_in  = cur_mismatch;
      armed_in     = cur_armed;
      value_in     = cur_value;
      length_in    = cur_length;
      negative_in  = cur_negative;
      count_in     = cur_count;
      out_region   = cur_region;
      hdr_end      = 1'b0;
      done         = 1'b0;
      unique case (cur_region)
         REGION_LINE: begin
            if (data_byte == CHAR_LF) begin
               region_in    = REGION_KEY;
               match_pos_in = 4'd0;
               mismatch_in  = 1'b0;
            end
         end
         REGION_KEY: begin
            if (data_byte == CHAR_COLON) begin
               if (!cur_mismatch && cur_pos == KEY_LEN) begin
                  armed_in = 1'b1;
               end
               value_in  = '{phase: PHASE_BLANK, accum: '0, sign: 1'b0};
               region_in = REGION_VALUE;
            end else if (data_byte == CHAR_LF) begin
               hdr_end = 1'b1;
               // A zero length completes the request on this very byte.
               if (cur_length == '0 && !cur_negative) begin
                  done      = 1'b1;
                  region_in = REGION_DONE;
               end else begin
                  region_in = REGION_BODY;
               end
            end else if (cur_pos < KEY_LEN) begin
               if (lower_byte != key_char(cur_pos)) begin
                  mismatch_in = 1'b1;
               end
               match_pos_in = cur_pos + 4'd1;
            end else begin
               mismatch_in = 1'b1;
            end
         end
         REGION_VALUE: begin
            if (data_byte == CHAR_CR) begin
               if (cur_armed) begin
                  armed_in    = 1'b0;
                  length_in   = cur_value.accum;
                  negative_in = cur_value.sign && (cur_value.accum != '0);
               end
            end else if (data_byte == CHAR_LF) begin
               region_in    = REGION_KEY;
               match_pos_in = 4'd0;
               mismatch_in  = 1'b0;
            end else begin
               value_in = value_step;
            end
         end
         REGION_BODY: begin
            count_in = count_inc;
            if (!cur_negative && count_inc == cur_length) begin
               done      = 1'b1;
               region_in = REGION_DONE;
            end
         end
         default: begin
            out_region = REGION_DONE;
            region_in  = REGION_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff    <= REGION_LINE;
         match_pos_ff <= 4'd0;
         mismatch_ff  <= 1'b0;
         armed_ff     <= 1'b0;
         value_ff     <= '{phase: PHASE_BLANK, accum: '0, sign: 1'b0};
         length_ff    <= '0;
         negative_ff  <= 1'b0;
         count_ff     <= '0;
      end else if (in_fire) begin
         region_ff    <= region_in;
         match_pos_ff <= match_pos_in;
         mismatch_ff  <= mismatch_in;
         armed_ff     <= armed_in;
         value_ff     <= value_in;
         length_ff    <= length_in;
         negative_ff  <= negative_in;
         count_ff     <= count_in;
      end
   end

   always_comb begin
      result.region          = out_region;
      result.header_end      = hdr_end;
      result.content_length  = to_out(length_in);
      result.length_negative = negative_in;
      result.body_count      = to_out(count_in);
      result.request_done    = done;
   end

endmodule

`default_nettype wire

@@ rtl/http_request_length_parser_top.sv @@
// ----------------------------------------------------------------------------
// HTTP request length parser
// Parses a request byte stream and reports region, length and body progress.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one request byte per word plus a new_request
//   flag that restarts the parser before that byte. A word is taken at a
//   rising edge with req_valid high and req_stall low.
//   The rsp_ channel returns exactly one result word per request byte: the
//   region the byte was handled in, header_end, the committed content
//   length and its sign flag, the body byte count and request_done.
//   A taken byte has its result word registered and on the rsp_ ports
//   from the cycle after it is taken. One byte is taken per cycle while
//   the receiver does not stall; the whole parse step sits between the
//   parser state and the result register, and its longest path is the
//   times-ten add of the length digit accumulator.
//   When the receiver stalls, the result word holds and req_stall is
//   raised so that no further byte is taken until the word leaves; a byte
//   is still taken in the same cycle in which the waiting word is taken.
//   Reset clears the parser to the request line state and empties the
//   result register.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_length_parser_top
   import hrlp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_new_request,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [2:0]                rsp_region,
   output logic                      rsp_header_end,
   output logic [OUT_WIDTH-1:0]      rsp_content_length,
   output logic                      rsp_length_negative,
   output logic [OUT_WIDTH-1:0]      rsp_body_count,
   output logic                      rsp_request_done
);

   logic       in_fire;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign in_fire   = req_valid && !req_stall;

   hrlp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (in_fire),
      .data_byte   (req_data_byte),
      .new_request (req_new_request),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         result_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_region          = result_ff.region;
   assign rsp_header_end      = result_ff.header_end;
   assign rsp_content_length  = result_ff.content_length;
   assign rsp_length_negative = result_ff.length_negative;
   assign rsp_body_count      = result_ff.body_count;
   assign rsp_request_done    = result_ff.request_done;

   // A taken byte always leaves a result word behind it.
   assert property (@(posedge clock) disable iff (reset)
      in_fire |=> rsp_valid_ff)
      else $error("taken byte produced no result word");

   // The header block can only end on a byte seen in a header key.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_header_end) |-> (rsp_region == REGION_KEY))
      else $error("header end outside a header key");

   // Completion happens at the header end or on a body byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_request_done) |->
         (rsp_header_end || rsp_region == REGION_BODY))
      else $error("request done outside header end or body");

   // A negative length never completes a request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_request_done) |-> !rsp_length_negative)
      else $error("request done with negative length");

endmodule

`default_nettype wire

@@ tb/tb_http_request_length_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the HTTP request length parser
// Streams requests through the parser with random idling on both sides and
// checks every result word against a cycle-free model of the byte parse.
// ----------------------------------------------------------------------------

module tb_http_request_length_parser_top
   import hrlp_pkg::*;
();

   localparam int TARGET_BYTES = 1900;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 27;
   localparam int QUIET_FROM   = 800;
   localparam int QUIET_TO     = 1150;
   localparam int DRAIN_CYCLES = 10;

   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] LOWER_Z     = 8'h7A;
   localparam logic [7:0] UPPER_A     = 8'h41;
   localparam logic [7:0] UPPER_Z     = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] FILLER      = 8'h78;

   // Models the parser byte by byte and holds the result words still owed.
   class length_parse_model;
      region_type              region_q;
      logic [3:0]              match_pos;
      bit                      mismatch;
      bit                      armed;
      phase_type               phase;
      logic [LENGTH_WIDTH-1:0] accum;
      bit                      sign;
      logic [LENGTH_WIDTH-1:0] length_val;
      bit                      negative;
      logic [LENGTH_WIDTH-1:0] body_cnt;
      string                   key_text = "content-length";
      result_type              pending_results[$];
      int                      errors, words_checked, requests, commits;
      int                      header_ends, completions, negatives, saturations;

      function new();
         clear_state();
      endfunction

      function void clear_state();
         region_q   = REGION_LINE;
         match_pos  = '0;
         mismatch   = 1'b0;
         armed      = 1'b0;
         phase      = PHASE_BLANK;
         accum      = '0;
         sign       = 1'b0;
         length_val = '0;
         negative   = 1'b0;
         body_cnt   = '0;
      endfunction

      function void take_byte(logic [7:0] c, bit restart);
         result_type              want;
         logic [7:0]              lc;
         logic [LENGTH_WIDTH+3:0] wide;
         bit                      blank;
         if (restart) begin
            clear_state();
            requests++;
         end
         want = '0;
         want.region = region_q;
         case (region_q)
            REGION_LINE: begin
               if (c == CHAR_LF) begin
                  region_q  = REGION_KEY;
                  match_pos = '0;
                  mismatch  = 1'b0;
               end
            end
            REGION_KEY: begin
               if (c == CHAR_COLON) begin
                  if (!mismatch && match_pos == KEY_LEN)
                     armed = 1'b1;
                  phase    = PHASE_BLANK;
                  accum    = '0;
                  sign     = 1'b0;
                  region_q = REGION_VALUE;
               end else if (c == CHAR_LF) begin
                  want.header_end = 1'b1;
                  header_ends++;
                  // With nothing to wait for, the request completes right here.
                  if (length_val == 0 && !negative) begin
                     want.request_done = 1'b1;
                     completions++;
                     region_q = REGION_DONE;
                  end else begin
                     region_q = REGION_BODY;
                  end
               end else begin
                  lc = c;
                  if (lc >= UPPER_A && lc <= UPPER_Z)
                     lc = lc + CASE_OFFSET;
                  if (match_pos < KEY_LEN) begin
                     if (lc != key_text[match_pos])
                        mismatch = 1'b1;
                     match_pos++;
                  end else begin
                     mismatch = 1'b1;
                  end
               end
            end
            REGION_VALUE: begin
               if (c == CHAR_CR) begin
                  if (armed) begin
                     armed      = 1'b0;
                     length_val = accum;
                     negative   = sign && accum != 0;
                     commits++;
                     if (negative)
                        negatives++;
                     if (accum == LENGTH_MAX)
                        saturations++;
                  end
               end else if (c == CHAR_LF) begin
                  region_q  = REGION_KEY;
                  match_pos = '0;
                  mismatch  = 1'b0;
               end else if (phase != PHASE_STOP) begin
                  blank = c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF;
                  if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                     wide  = accum * 10 + (c - CHAR_ZERO);
                     accum = (wide > LENGTH_MAX) ? LENGTH_MAX : wide[LENGTH_WIDTH-1:0];
                     phase = PHASE_DIGITS;
                  end else if (phase == PHASE_BLANK && blank) begin
                     // Leading blanks are skipped.
                  end else if (phase == PHASE_BLANK && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
                     sign  = c == CHAR_MINUS;
                     phase = PHASE_DIGITS;
                  end else begin
                     phase = PHASE_STOP;
                  end
               end
            end
            REGION_BODY: begin
               if (body_cnt != LENGTH_MAX)
                  body_cnt++;
               if (!negative && body_cnt == length_val) begin
                  want.request_done = 1'b1;
                  completions++;
                  region_q = REGION_DONE;
               end
            end
            default: begin
               want.region = REGION_DONE;
               region_q    = REGION_DONE;
            end
         endcase
         want.content_length  = length_val;
         want.length_negative = negative;
         want.body_count      = body_cnt;
         pending_results.push_back(want);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10)
            $display("MISMATCH: %s", msg);
      endfunction

      function void match_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            flag($sformatf("result word with nothing owed, region %0d", got.region));
            return;
         end
         want = pending_results.pop_front();
         if (want.region != got.region || want.header_end != got.header_end ||
             want.content_length != got.content_length ||
             want.length_negative != got.length_negative ||
             want.body_count != got.body_count || want.request_done != got.request_done)
            flag($sformatf({"word %0d: expected region %0d hdr_end %0b len %0d neg %0b ",
                            "count %0d done %0b, got region %0d hdr_end %0b len %0d neg %0b ",
                            "count %0d done %0b"}, words_checked,
                           want.region, want.header_end, want.content_length,
                           want.length_negative, want.body_count, want.request_done,
                           got.region, got.header_end, got.content_length,
                           got.length_negative, got.body_count, got.request_done));
         words_checked++;
      endfunction
   endclass

   typedef struct packed {
      logic       restart;
      logic [7:0] data;
   } stream_word_type;

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_data_byte   = '0;
   logic                 req_new_request = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [2:0]           rsp_region;
   logic                 rsp_header_end;
   logic [OUT_WIDTH-1:0] rsp_content_length;
   logic                 rsp_length_negative;
   logic [OUT_WIDTH-1:0] rsp_body_count;
   logic                 rsp_request_done;

   length_parse_model parser = new();
   stream_word_type   stream_q[$];
   int                sent_count = 0;
   int                cycle_count = 0;
   bit                quiet = 1'b0;

   http_request_length_parser_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_new_request     (req_new_request),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_region          (rsp_region),
      .rsp_header_end      (rsp_header_end),
      .rsp_content_length  (rsp_content_length),
      .rsp_length_negative (rsp_length_negative),
      .rsp_body_count      (rsp_body_count),
      .rsp_request_done    (rsp_request_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words owed", cycle_count,
                  parser.pending_results.size());
         $display("tb_http_request_length_parser_top: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || quiet)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= $urandom_range(99) < IDLE_PERCENT;
   end

   always @(posedge clock) begin : watch_results
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.region          = region_type'(rsp_region);
         got.header_end      = rsp_header_end;
         got.content_length  = rsp_content_length;
         got.length_negative = rsp_length_negative;
         got.body_count      = rsp_body_count;
         got.request_done    = rsp_request_done;
         parser.match_result(got);
      end
   end

   task automatic push_byte(input logic [7:0] b, input bit restart);
      stream_word_type w;
      w.restart = restart;
      w.data    = b;
      stream_q.push_back(w);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i], 1'b0);
   endtask

   // A random byte that cannot end the current line or split the key.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == CHAR_CR || b == CHAR_LF || b == CHAR_COLON)
         b = FILLER;
      return b;
   endfunction

   task automatic send_stream();
      stream_word_type w;
      while (stream_q.size() != 0) begin
         w = stream_q.pop_front();
         while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid       <= 1'b1;
         req_data_byte   <= w.data;
         req_new_request <= w.restart;
         @(posedge clock);
         while (req_stall)
            @(posedge clock);
         parser.take_byte(w.data, w.restart);
         sent_count++;
         quiet = sent_count >= QUIET_FROM && sent_count < QUIET_TO;
      end
   endtask

   // Builds one request: mostly well formed with random content, some noise.
   task automatic build_request();
      int         kind, variant, num, term, body_len;
      bit         exact, minus;
      logic [7:0] b;
      longint     body_target;
      body_target = 0;
      if ($urandom_range(99) < 8) begin
         push_byte(8'($urandom_range(255)), $urandom_range(3) != 0);
         repeat ($urandom_range(30))
            push_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
         return;
      end
      push_byte(plain_byte(), $urandom_range(9) != 0);
      repeat ($urandom_range(8)) push_byte(plain_byte(), 1'b0);
      if ($urandom_range(3) != 0)
         push_byte(CHAR_CR, 1'b0);
      push_byte(CHAR_LF, 1'b0);
      repeat ($urandom_range(3)) begin
         kind = $urandom_range(99);
         if (kind < 55) begin
            variant = $urandom_range(19);
            exact   = variant > 2;
            for (int i = 0; i < KEY_LEN - (variant == 1); i++) begin
               b = parser.key_text[i];
               if (b >= LOWER_A && b <= LOWER_Z && $urandom_range(1))
                  b = b - CASE_OFFSET;
               if (variant == 2 && i == $urandom_range(13))
                  b = FILLER;
               push_byte(b, 1'b0);
            end
            if (variant == 0)
               push_text("s");
            push_byte(CHAR_COLON, 1'b0);
            repeat ($urandom_range(2)) begin
               case ($urandom_range(3))
                  0: push_byte(CHAR_SPACE, 1'b0);
                  1: push_byte(CHAR_TAB, 1'b0);
                  2: push_byte(CHAR_VT, 1'b0);
                  default: push_byte(CHAR_FF, 1'b0);
               endcase
            end
            minus = 1'b0;
            case ($urandom_range(9))
               0: push_byte(CHAR_PLUS, 1'b0);
               1: begin
                  push_byte(CHAR_MINUS, 1'b0);
                  minus = 1'b1;
               end
               default: ;
            endcase
            kind = $urandom_range(99);
            if (kind < 5) begin
               num = 0;
            end else if (kind < 85) begin
               num = (kind < 70) ? $urandom_range(40) : $urandom_range(99999);
               if ($urandom_range(9) == 0)
                  push_byte(CHAR_ZERO, 1'b0);
               push_text($sformatf("%0d", num));
            end else begin
               // Eight to ten random digits, which can overflow the length register.
               num = LENGTH_MAX;
               repeat ($urandom_range(10, 8))
                  push_byte(CHAR_ZERO + 8'($urandom_range(9)), 1'b0);
            end
            if ($urandom_range(6) == 0) begin
               push_byte(plain_byte(), 1'b0);
               push_text("7");
            end
            term = $urandom_range(19);
            if (term != 0)
               push_byte(CHAR_CR, 1'b0);
            push_byte(CHAR_LF, 1'b0);
            if (exact && term != 0)
               body_target = (minus && num != 0) ? -1 : num;
         end else if (kind < 93) begin
            repeat ($urandom_range(10, 1)) push_byte(plain_byte(), 1'b0);
            push_byte(CHAR_COLON, 1'b0);
            repeat ($urandom_range(8)) push_byte(plain_byte(), 1'b0);
            push_byte(CHAR_CR, 1'b0);
            push_byte(CHAR_LF, 1'b0);
         end else begin
            // A line with no colon ends the header block early.
            repeat ($urandom_range(6, 1)) push_byte(plain_byte(), 1'b0);
            push_byte(CHAR_CR, 1'b0);
            push_byte(CHAR_LF, 1'b0);
         end
      end
      if ($urandom_range(9) != 0)
         push_byte(CHAR_CR, 1'b0);
      push_byte(CHAR_LF, 1'b0);
      body_len = (body_target >= 0 && body_target <= 60) ? int'(body_target)
                                                       : $urandom_range(40);
      if ($urandom_range(9) == 0)
         body_len = $urandom_range(body_len);
      if ($urandom_range(6) == 0)
         body_len += $urandom_range(4, 1);
      repeat (body_len) push_byte(8'($urandom_range(255)), 1'b0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Byte extremes in the request line, then a negative length whose body
      // never completes, so the trailing bytes stay in the body region.
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(CHAR_CR, 1'b0);
      push_byte(CHAR_LF, 1'b0);
      push_text("content-length:-5");
      push_byte(CHAR_CR, 1'b0);
      push_byte(CHAR_LF, 1'b0);
      push_byte(CHAR_LF, 1'b0);
      push_byte(UPPER_A, 1'b0);
      push_byte(UPPER_Z, 1'b0);
      send_stream();

      while (sent_count < TARGET_BYTES) begin
         build_request();
         send_stream();
      end
      req_valid <= 1'b0;

      while (parser.pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (parser.pending_results.size() != 0)
         parser.flag($sformatf("%0d result words never arrived",
                               parser.pending_results.size()));

      $display("Covered %0d request bytes in %0d restarted requests: %0d length commits",
               sent_count, parser.requests, parser.commits);
      $display("(%0d negative, %0d saturated), %0d header ends, %0d completed bodies.",
               parser.negatives, parser.saturations, parser.header_ends, parser.completions);
      if (parser.errors == 0)
         $display("tb_http_request_length_parser_top: clean");
      else
         $display("tb_http_request_length_parser_top: errors");
      $finish;
   end

endmodule

@@ http_request_length_parser_top.f @@
rtl/hrlp_pkg.sv
rtl/hrlp_value_unit.sv
rtl/hrlp_parser.sv
rtl/http_request_length_parser_top.sv
tb/tb_http_request_length_parser_top.sv
